### rtl/lms_pkg.sv
// ----------------------------------------------------------------------------
// lms_pkg
// Shared widths, pipeline record and arithmetic steps of the lens remapper.
// ----------------------------------------------------------------------------
package lms_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_DIM     = 1024;
  localparam int DIM_W       = 11;
  localparam int PIX_W       = 10;
  localparam int OFF_W       = DIM_W + 1;
  localparam int SQ_W        = 2 * DIM_W;
  localparam int S4_W        = SQ_W + 3;
  localparam int REM_W       = SQ_W + 1;
  localparam int FR_W        = FRAC_BITS + 1;
  localparam int SREM_W      = FR_W + 3;
  localparam int ROOT_STEPS  = 9;
  localparam logic [ROOT_STEPS:0] EXP_MASK = 10'h334;
  localparam int DIV_DPS     = 4;
  localparam int DIV_STAGES  = FRAC_BITS / DIV_DPS;
  localparam int SQ_DIGITS   = FR_W;
  localparam int SQ_DPS      = 3;
  localparam int ROOT_STAGES = (SQ_DIGITS + SQ_DPS - 1) / SQ_DPS;
  localparam int PIPE_LAST   = DIV_STAGES + ROOT_STEPS * ROOT_STAGES + 1;
  // front three, pipe record stages, two axis stages, output register
  localparam int LATENCY     = 3 + PIPE_LAST + 2 + 1;
  localparam int NUM_W       = DIM_W + FRAC_BITS + 3;

  localparam logic [DIM_W-1:0] RESET_DIM = 11'd600;
  localparam logic [FR_W-1:0]  ONE       = FR_W'(1) << FRAC_BITS;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic                    vld;
    logic                    ins;
    logic [PIX_W-1:0]        px;
    logic [PIX_W-1:0]        py;
    logic signed [OFF_W-1:0] dx2;
    logic signed [OFF_W-1:0] dy2;
    logic [REM_W-1:0]        rem;
    logic [FR_W-1:0]         root;
    logic [FR_W-1:0]         rsrc;
    logic [FR_W-1:0]         acc;
  } pipe_t;

  typedef struct packed {
    logic             vld;
    logic             ins;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
  } ctl_t;

  // one restoring quotient bit: returns {bit, remainder}
  function automatic logic [REM_W:0] div_step(logic [REM_W-1:0] rem,
                                             logic [SQ_W-1:0] m2);
    logic [REM_W:0] t;
    logic [REM_W:0] d;
    t = {rem, 1'b0};
    d = t - {2'b00, m2};
    if (t >= {2'b00, m2}) begin
      return {1'b1, d[REM_W-1:0]};
    end
    return {1'b0, t[REM_W-1:0]};
  endfunction

  // one digit of the floor square root: returns {root, remainder}
  function automatic logic [FR_W+SREM_W-1:0] sqrt_step(logic [SREM_W-1:0] rem,
                                                      logic [FR_W-1:0] root,
                                                      logic [1:0] pair);
    logic [SREM_W+1:0] t;
    logic [SREM_W+1:0] trial;
    logic [SREM_W+1:0] d;
    t     = {rem, pair};
    trial = {3'b000, root, 2'b01};
    d     = t - trial;
    if (t >= trial) begin
      return {root[FR_W-2:0], 1'b1, d[SREM_W-1:0]};
    end
    return {root[FR_W-2:0], 1'b0, t[SREM_W-1:0]};
  endfunction

  // digit pair of src << FRAC_BITS, most significant pair first
  function automatic logic [1:0] rad_pair(logic [FR_W-1:0] src, int d);
    logic [FR_W:0] s;
    int p;
    s = {1'b0, src};
    p = SQ_DIGITS - 1 - d;
    if (p < FRAC_BITS / 2) begin
      return 2'b00;
    end
    return s[2*(p-FRAC_BITS/2) +: 2];
  endfunction

  function automatic logic [FR_W-1:0] mul_frac(logic [FR_W-1:0] a, logic [FR_W-1:0] b);
    logic [2*FR_W-1:0] p;
    p = a * b;
    return p[FRAC_BITS +: FR_W];
  endfunction

endpackage

### rtl/lens_magnify_source_coordinate.sv
// ----------------------------------------------------------------------------
// lens_magnify_source_coordinate
// Source pixel address generator for a radial magnifying lens.
// ----------------------------------------------------------------------------
// A pixel (pixel_x, pixel_y) is taken when start is high and busy is low;
// busy stays low, so one pixel may be issued on every clock. Each pixel
// gives one result, shown on source_x, source_y and inside_lens for one
// cycle with done high. Results leave in issue order and the receiver
// cannot stall them. The pipeline is a fixed chain of stages: an
// offset stage, a squaring stage and a lens test, a four-stage divider
// for (d/R)^2, then nine chained square roots of six stages each with
// the scale products folded in, one product stage, two stages per axis
// for the final remap and the output register.
// Pixels outside the lens come back unchanged with inside_lens low.
// Reset empties the pipeline (no done until new pixels arrive) and sets
// image_width and image_height to 600. The APB port holds the two frame
// registers at byte addresses 0 and 4; change them only while no pixel
// is in flight.
module lens_magnify_source_coordinate import lms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [PIX_W-1:0]  pixel_x,
  input  logic [PIX_W-1:0]  pixel_y,
  output logic              done,
  output logic [PIX_W-1:0]  source_x,
  output logic [PIX_W-1:0]  source_y,
  output logic              inside_lens,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [DIM_W-1:0] m;
  logic [SQ_W-1:0]  m2;
  logic             m_nz;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign prdata = {21'b0, (paddr[2] == REG_HEIGHT) ? image_height : image_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_DIM;
      image_height <= RESET_DIM;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WIDTH) begin
        image_width <= pwdata[DIM_W-1:0];
      end else begin
        image_height <= pwdata[DIM_W-1:0];
      end
    end
  end

  assign m = (image_width < image_height) ? image_width : image_height;

  always_ff @(posedge clk) begin
    m2   <= m * m;
    m_nz <= (m != '0);
  end

  // offsets from centre, doubled
  logic                    s1_vld;
  logic [PIX_W-1:0]        s1_px, s1_py;
  logic signed [OFF_W-1:0] s1_dx2, s1_dy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
    end
    s1_px  <= pixel_x;
    s1_py  <= pixel_y;
    s1_dx2 <= $signed({1'b0, pixel_x, 1'b0}) - $signed({1'b0, image_width});
    s1_dy2 <= $signed({1'b0, pixel_y, 1'b0}) - $signed({1'b0, image_height});
  end

  logic                    s2_vld;
  logic [PIX_W-1:0]        s2_px, s2_py;
  logic signed [OFF_W-1:0] s2_dx2, s2_dy2;
  logic [SQ_W-1:0]         s2_dxs, s2_dys;
  logic signed [2*OFF_W-1:0] dxp, dyp;

  assign dxp = s1_dx2 * s1_dx2;
  assign dyp = s1_dy2 * s1_dy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_px  <= s1_px;
    s2_py  <= s1_py;
    s2_dx2 <= s1_dx2;
    s2_dy2 <= s1_dy2;
    s2_dxs <= dxp[SQ_W-1:0];
    s2_dys <= dyp[SQ_W-1:0];
  end

  pipe_t pl [0:PIPE_LAST];

  // lens test and integer bit of the ratio
  logic [S4_W-1:0] s4;
  logic [S4_W-1:0] s4_sub;
  logic            q_int;
  pipe_t           p0;

  assign s4     = {1'b0, {1'b0, s2_dxs} + {1'b0, s2_dys}, 1'b0} << 1;
  assign s4_sub = s4 - {3'b000, m2};
  assign q_int  = (s4 >= {3'b000, m2});

  always_comb begin
    p0      = '0;
    p0.vld  = s2_vld;
    p0.ins  = m_nz && (s4 <= {3'b000, m2});
    p0.px   = s2_px;
    p0.py   = s2_py;
    p0.dx2  = s2_dx2;
    p0.dy2  = s2_dy2;
    p0.rem  = q_int ? s4_sub[REM_W-1:0] : s4[REM_W-1:0];
    p0.root = {{(FR_W-1){1'b0}}, q_int};
    p0.acc  = ONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pl[0] <= '0;
    end else begin
      pl[0] <= p0;
    end
  end

  // fractional quotient bits, collected in root
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    pipe_t nx;
    always_comb begin
      logic [REM_W:0] r;
      nx = pl[i];
      for (int j = 0; j < DIV_DPS; j++) begin
        r       = div_step(nx.rem, m2);
        nx.rem  = r[REM_W-1:0];
        nx.root = {nx.root[FR_W-2:0], r[REM_W]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        pl[i+1] <= '0;
      end else begin
        pl[i+1] <= nx;
      end
    end
  end

  // chained roots q^(1/2^k); product takes previous root on entry per EXP_MASK
  for (genvar k = 1; k <= ROOT_STEPS; k++) begin : g_root
    for (genvar st = 0; st < ROOT_STAGES; st++) begin : g_st
      localparam int IDX = DIV_STAGES + (k - 1) * ROOT_STAGES + st;
      pipe_t nx;
      always_comb begin
        logic [FR_W+SREM_W-1:0] r;
        nx = pl[IDX];
        if (st == 0) begin
          nx.rsrc = pl[IDX].root;
          if (EXP_MASK[k-1]) begin
            nx.acc = mul_frac(pl[IDX].acc, pl[IDX].root);
          end
          nx.root = '0;
          nx.rem  = '0;
        end
        for (int j = 0; j < SQ_DPS; j++) begin
          if (st * SQ_DPS + j < SQ_DIGITS) begin
            r       = sqrt_step(nx.rem[SREM_W-1:0], nx.root,
                                rad_pair(nx.rsrc, st * SQ_DPS + j));
            nx.root = r[FR_W+SREM_W-1:SREM_W];
            nx.rem  = REM_W'(r[SREM_W-1:0]);
          end
        end
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          pl[IDX+1] <= '0;
        end else begin
          pl[IDX+1] <= nx;
        end
      end
    end
  end

  pipe_t pf;

  always_comb begin
    pf = pl[PIPE_LAST-1];
    if (EXP_MASK[ROOT_STEPS]) begin
      pf.acc = mul_frac(pl[PIPE_LAST-1].acc, pl[PIPE_LAST-1].root);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pl[PIPE_LAST] <= '0;
    end else begin
      pl[PIPE_LAST] <= pf;
    end
  end

  // per-axis remap, control rides alongside
  logic [PIX_W-1:0] cx, cy;
  logic             okx, oky;
  ctl_t             tail [0:1];

  lms_axis u_axis_x (
    .clk   (clk),
    .dim   (image_width),
    .off2  (pl[PIPE_LAST].dx2),
    .scale (pl[PIPE_LAST].acc),
    .coord (cx),
    .ok    (okx)
  );

  lms_axis u_axis_y (
    .clk   (clk),
    .dim   (image_height),
    .off2  (pl[PIPE_LAST].dy2),
    .scale (pl[PIPE_LAST].acc),
    .coord (cy),
    .ok    (oky)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tail[0] <= '0;
      tail[1] <= '0;
    end else begin
      tail[0] <= '{vld: pl[PIPE_LAST].vld, ins: pl[PIPE_LAST].ins,
                   px: pl[PIPE_LAST].px, py: pl[PIPE_LAST].py};
      tail[1] <= tail[0];
    end
  end

  logic remap;
  assign remap = tail[1].ins && okx && oky;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tail[1].vld;
    end
    source_x    <= remap ? cx : tail[1].px;
    source_y    <= remap ? cy : tail[1].py;
    inside_lens <= remap;
  end

endmodule

### rtl/lms_axis.sv
// ----------------------------------------------------------------------------
// lms_axis
// Two-stage remap of one axis: centre plus scaled offset, floor and bounds.
// ----------------------------------------------------------------------------
module lms_axis import lms_pkg::*; (
  input  logic                    clk,
  input  logic [DIM_W-1:0]        dim,
  input  logic signed [OFF_W-1:0] off2,
  input  logic [FR_W-1:0]         scale,
  output logic [PIX_W-1:0]        coord,
  output logic                    ok
);

  logic signed [NUM_W-1:0]   prod;
  logic signed [NUM_W-1:0]   num;
  logic [NUM_W-FRAC_BITS-3:0] v;
  logic signed [OFF_W+FR_W:0] prod_full;

  assign prod_full = off2 * $signed({1'b0, scale});

  always_ff @(posedge clk) begin
    prod <= NUM_W'(prod_full);
  end

  assign num = $signed({3'b000, dim, FRAC_BITS'(0)}) + prod;
  assign v   = num[NUM_W-2:FRAC_BITS+1];

  always_ff @(posedge clk) begin
    coord <= v[PIX_W-1:0];
    ok    <= !num[NUM_W-1] && (v < {1'b0, dim}) && (v < (NUM_W-FRAC_BITS-2)'(MAX_DIM));
  end

endmodule

### rtl/lms_checker.sv
// ----------------------------------------------------------------------------
// lms_checker
// Port-level timing and pass-through checks for the lens remapper.
// ----------------------------------------------------------------------------
module lms_checker import lms_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic [PIX_W-1:0] pixel_x,
  input logic [PIX_W-1:0] pixel_y,
  input logic             done,
  input logic [PIX_W-1:0] source_x,
  input logic [PIX_W-1:0] source_y,
  input logic             inside_lens
);

  localparam int AGE_W = $clog2(LATENCY + 1);

  logic [AGE_W-1:0] age;
  logic             warm;

  // cycles since reset, saturating once the pipeline has filled
  always_ff @(posedge clk) begin
    if (rst) begin
      age <= '0;
    end else if (age != AGE_W'(LATENCY)) begin
      age <= age + 1'b1;
    end
  end

  assign warm = (age == AGE_W'(LATENCY));

  a_latency: assert property (@(posedge clk) disable iff (rst)
    warm |-> (done == $past(start && !busy, LATENCY)))
    else $error("result strobe does not follow start by the fixed latency");

  a_passthru: assert property (@(posedge clk) disable iff (rst)
    (warm && done && !inside_lens) |->
      (source_x == $past(pixel_x, LATENCY) && source_y == $past(pixel_y, LATENCY)))
    else $error("pixel outside the lens was not returned unchanged");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

bind lens_magnify_source_coordinate lms_checker u_lms_checker (.*);
